>>> hw/rtl/l2_bridge_forward_filter_assert.svh
// Assertion macros for the layer-2 bridge forward filter.
// Included by the top level; needs nothing else.
`ifndef L2_BRIDGE_FORWARD_FILTER_ASSERT_SVH
`define L2_BRIDGE_FORWARD_FILTER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define L2BFF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define L2BFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/l2bff_pkg.sv
// Types and constants shared by the layer-2 bridge forward filter.
// No dependencies.
`timescale 1ns / 1ps

package l2bff_pkg;

   localparam int MAC_W          = 48;
   localparam int CHAN_W         = 16;
   localparam int ETYPE_W        = 16;
   localparam int OPCODE_W       = 3;
   localparam int ENTRY_INDEX_W  = 5;
   localparam int FILTER_COUNT_W = 6;
   localparam int ROUTE_W        = 2;
   localparam int CSR_INDEX_W    = 2;

   typedef logic [MAC_W-1:0]          mac_type;
   typedef logic [CHAN_W-1:0]         chan_type;
   typedef logic [ETYPE_W-1:0]        etype_type;
   typedef logic [OPCODE_W-1:0]       opcode_type;
   typedef logic [ENTRY_INDEX_W-1:0]  entry_index_type;
   typedef logic [FILTER_COUNT_W-1:0] filter_count_type;
   typedef logic [ROUTE_W-1:0]        route_type;
   typedef logic [CSR_INDEX_W-1:0]    csr_index_type;

   localparam opcode_type OP_WIRED     = 3'd0;
   localparam opcode_type OP_PEER_DATA = 3'd1;
   localparam opcode_type OP_OPEN      = 3'd2;
   localparam opcode_type OP_CLOSE     = 3'd3;
   localparam opcode_type OP_WRITE     = 3'd4;

   localparam route_type ROUTE_NONE  = 2'd0;
   localparam route_type ROUTE_LOCAL = 2'd1;
   localparam route_type ROUTE_PEER  = 2'd2;

   localparam csr_index_type CSR_LOCAL_MAC    = 2'd0;
   localparam csr_index_type CSR_LIST_SENSE   = 2'd1;
   localparam csr_index_type CSR_FILTER_COUNT = 2'd2;

   localparam logic LIST_SENSE_ALLOW = 1'b0;

   localparam mac_type   MAC_BROADCAST = {MAC_W{1'b1}};
   localparam etype_type ETYPE_ARP     = 16'h0806;

   typedef struct packed {
      opcode_type      opcode;
      mac_type         mac_addr;
      etype_type       ethertype;
      logic            open_ok;
      chan_type        link_channel;
      entry_index_type entry_index;
   } req_item_type;

   typedef struct packed {
      route_type route;
      logic      disconnect;
      logic      link_up;
      chan_type  current_channel;
   } rsp_item_type;

   typedef struct packed {
      mac_type          local_mac;
      logic             list_sense;
      filter_count_type filter_count;
   } cfg_type;

   typedef struct packed {
      logic            en;
      entry_index_type index;
      mac_type         data;
   } acl_wr_type;

endpackage

>>> hw/rtl/l2bff_if.sv
// Handshake channel interfaces of the layer-2 bridge forward filter.
// Depends on l2bff_pkg for the payload widths.
`timescale 1ns / 1ps

interface l2bff_req_if import l2bff_pkg::*; ();
   logic            valid;
   logic            ready;
   opcode_type      opcode;
   mac_type         mac_addr;
   etype_type       ethertype;
   logic            open_ok;
   chan_type        link_channel;
   entry_index_type entry_index;

   modport source (output valid, output opcode, output mac_addr, output ethertype,
                   output open_ok, output link_channel, output entry_index, input ready);
   modport sink   (input valid, input opcode, input mac_addr, input ethertype,
                   input open_ok, input link_channel, input entry_index, output ready);
endinterface

interface l2bff_rsp_if import l2bff_pkg::*; ();
   logic      valid;
   logic      ready;
   route_type route;
   logic      disconnect;
   logic      link_up;
   chan_type  current_channel;

   modport source (output valid, output route, output disconnect, output link_up,
                   output current_channel, input ready);
   modport sink   (input valid, input route, input disconnect, input link_up,
                   input current_channel, output ready);
endinterface

interface l2bff_csr_if import l2bff_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   mac_type       wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> hw/rtl/l2bff_acl.sv
// MAC access list: one register and one comparator per entry, all lanes in parallel.
// Depends on l2bff_pkg.
`timescale 1ns / 1ps

module l2bff_acl import l2bff_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input  logic       clock,
   input  acl_wr_type wr,
   input  cfg_type    cfg,
   input  mac_type    query,
   output logic       admit
);

   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int LANE_W = (CNT_W > FILTER_COUNT_W) ? CNT_W : FILTER_COUNT_W;

   // Entries are not reset; a lane below the count that was never written is
   // a usage error.
   mac_type                 entry_ff [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]   lane_hit;
   logic [LANE_W-1:0]       count_ext;
   logic [LANE_W-1:0]       wr_index_ext;

   assign count_ext    = LANE_W'(cfg.filter_count);
   assign wr_index_ext = LANE_W'(wr.index);

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_lane
      localparam logic [LANE_W-1:0] LANE = LANE_W'(g);

      always_ff @(posedge clock) begin
         if (wr.en && (wr_index_ext == LANE)) begin
            entry_ff[g] <= wr.data;
         end
      end

      // A count above the depth simply enables every lane.
      assign lane_hit[g] = (LANE < count_ext) && (entry_ff[g] == query);
   end

   assign admit = (cfg.list_sense == LIST_SENSE_ALLOW) ? (|lane_hit) : ~(|lane_hit);

endmodule

>>> hw/rtl/l2bff_decide.sv
// Link state and forwarding decision for one word per cycle when fire is high.
// Depends on l2bff_pkg; the access list verdict comes from l2bff_acl.
`timescale 1ns / 1ps

module l2bff_decide import l2bff_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   input  logic         admit,
   output rsp_item_type result
);

   logic     connected_ff, connected_in;
   mac_type  peer_mac_ff, peer_mac_in;
   chan_type active_channel_ff, active_channel_in;
   logic     bcast;
   logic     arp;
   route_type route;
   logic     disconnect;

   assign bcast = (item.mac_addr == MAC_BROADCAST);
   assign arp   = (item.ethertype == ETYPE_ARP);

   always_comb begin
      connected_in      = connected_ff;
      peer_mac_in       = peer_mac_ff;
      active_channel_in = active_channel_ff;
      route             = ROUTE_NONE;
      disconnect        = 1'b0;
      unique case (item.opcode)
         OP_WIRED: begin
            priority if ((item.mac_addr == cfg.local_mac) || (bcast && !arp)) begin
               route = ROUTE_LOCAL;
            end else if (connected_ff && ((item.mac_addr == peer_mac_ff) || (bcast && arp))) begin
               route = ROUTE_PEER;
            end else begin
               route = ROUTE_NONE;
            end
         end
         OP_PEER_DATA: begin
            // The source address is learnt even while the link is down.
            peer_mac_in = item.mac_addr;
         end
         OP_OPEN: begin
            // A rejected peer leaves the link state alone whatever the open status.
            if (!admit) begin
               disconnect = 1'b1;
            end else if (item.open_ok) begin
               active_channel_in = item.link_channel;
               peer_mac_in       = item.mac_addr;
               connected_in      = 1'b1;
            end
         end
         OP_CLOSE: begin
            connected_in = 1'b0;
            peer_mac_in  = '0;
         end
         default: begin
            // List writes are handled by the access list; other codes do nothing.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff      <= 1'b0;
         peer_mac_ff       <= '0;
         active_channel_ff <= '0;
      end else if (fire) begin
         connected_ff      <= connected_in;
         peer_mac_ff       <= peer_mac_in;
         active_channel_ff <= active_channel_in;
      end
   end

   assign result.route           = route;
   assign result.disconnect      = disconnect;
   assign result.link_up         = connected_in;
   assign result.current_channel = active_channel_in;

endmodule

>>> hw/rtl/l2_bridge_forward_filter.sv
// Layer-2 bridge forward filter: input register, decision stage and result register.
// Depends on l2bff_pkg, l2bff_if, l2bff_acl, l2bff_decide and the assertion header.
`timescale 1ns / 1ps
`include "l2_bridge_forward_filter_assert.svh"

// Takes one word per clock cycle when the result side is not stalled and returns
// exactly one result word for each, in order, from the result register.
// The decision stage sits between the input register and the result register;
// its longest path is the parallel compare of the looked-up MAC against all
// LIST_DEPTH access list entries, followed by the OR of the lane hits. Link
// state and list writes take effect for the very next word. While a finished
// result waits in the result register, one further word is still accepted into
// the input register; after that the input is held off until the result is
// taken. Register writes are taken at once and must only be issued while the
// block is idle.
module l2_bridge_forward_filter import l2bff_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input logic         clock,
   input logic         reset,
   l2bff_req_if.sink   req_ch,
   l2bff_rsp_if.source rsp_ch,
   l2bff_csr_if.sink   csr_ch
);

   cfg_type      cfg_ff, cfg_in;
   logic         s1_vld_ff, s1_vld_in;
   req_item_type s1_item_ff;
   logic         out_vld_ff, out_vld_in;
   rsp_item_type out_item_ff;
   req_item_type req_item;
   rsp_item_type result;
   acl_wr_type   acl_wr;
   logic         admit;
   logic         req_fire;
   logic         out_open;
   logic         s1_fire;

   // Register file.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_LOCAL_MAC:    cfg_in.local_mac    = csr_ch.wdata;
            CSR_LIST_SENSE:   cfg_in.list_sense   = csr_ch.wdata[0];
            CSR_FILTER_COUNT: cfg_in.filter_count = csr_ch.wdata[FILTER_COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline control.
   assign out_open     = !out_vld_ff || rsp_ch.ready;
   assign s1_fire      = s1_vld_ff && out_open;
   assign req_ch.ready = !s1_vld_ff || out_open;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign s1_vld_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_ff);
   assign out_vld_in = s1_fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign req_item.opcode       = req_ch.opcode;
   assign req_item.mac_addr     = req_ch.mac_addr;
   assign req_item.ethertype    = req_ch.ethertype;
   assign req_item.open_ok      = req_ch.open_ok;
   assign req_item.link_channel = req_ch.link_channel;
   assign req_item.entry_index  = req_ch.entry_index;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (s1_fire) begin
         out_item_ff <= result;
      end
   end

   // Decision stage.
   assign acl_wr.en    = s1_fire && (s1_item_ff.opcode == OP_WRITE);
   assign acl_wr.index = s1_item_ff.entry_index;
   assign acl_wr.data  = s1_item_ff.mac_addr;

   l2bff_acl #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_acl (
      .clock (clock),
      .wr    (acl_wr),
      .cfg   (cfg_ff),
      .query (s1_item_ff.mac_addr),
      .admit (admit)
   );

   l2bff_decide u_decide (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .admit  (admit),
      .result (result)
   );

   assign rsp_ch.valid           = out_vld_ff;
   assign rsp_ch.route           = out_item_ff.route;
   assign rsp_ch.disconnect      = out_item_ff.disconnect;
   assign rsp_ch.link_up         = out_item_ff.link_up;
   assign rsp_ch.current_channel = out_item_ff.current_channel;

   // A frame can only be sent to the peer while the link is up.
   `L2BFF_ASSERT_SAME(a_peer_needs_link, clock, reset,
      rsp_ch.valid && (rsp_ch.route == ROUTE_PEER), rsp_ch.link_up,
      "peer route reported with the link down")

   // A disconnect only ever comes from an open event, which never routes.
   `L2BFF_ASSERT_SAME(a_disc_no_route, clock, reset,
      rsp_ch.valid && rsp_ch.disconnect, rsp_ch.route == ROUTE_NONE,
      "disconnect reported together with a route")

   // An accepted word must be held in the input register in the next cycle.
   `L2BFF_ASSERT_NEXT(a_accept_loads_stage, clock, reset,
      req_fire, s1_vld_ff,
      "accepted word lost before the decision stage")

endmodule

>>> dv/tb_l2_bridge_forward_filter.sv
// Self-checking testbench for the layer-2 bridge forward filter.
// Depends on l2bff_pkg, the l2bff_if channel interfaces and the l2_bridge_forward_filter RTL.
`timescale 1ns / 1ps

module tb_l2_bridge_forward_filter;
   import l2bff_pkg::*;

   localparam int ACL_DEPTH      = 32;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 250;
   localparam int PHASE_WORDS    = 230;

   localparam logic LIST_SENSE_DENY = 1'b1;

   // Opcodes the block does not define; they must leave the state alone.
   localparam opcode_type OP_RSVD5 = 3'd5;
   localparam opcode_type OP_RSVD6 = 3'd6;
   localparam opcode_type OP_RSVD7 = 3'd7;

   logic clock;
   logic reset;

   l2bff_req_if req_bus ();
   l2bff_rsp_if rsp_bus ();
   l2bff_csr_if csr_bus ();

   l2_bridge_forward_filter #(.LIST_DEPTH(ACL_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Mirror of the block's registers and link state.
   mac_type          cfg_local_mac;
   logic             cfg_list_sense;
   filter_count_type cfg_filter_count;
   logic             link_connected;
   mac_type          learned_peer;
   chan_type         active_chan;
   mac_type          acl [ACL_DEPTH];

   mac_type      mac_pool [8];
   rsp_item_type expected_rsp_q [$];

   bit          sender_gaps;
   bit          receiver_stalls;
   int unsigned rsp_hold_req;
   int unsigned mismatch_count;
   int unsigned words_sent;
   int unsigned results_checked;
   int unsigned settings_applied;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic mac_type rand_mac();
      return {16'($urandom()), $urandom()};
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(15, 60);
   endfunction

   function automatic rsp_item_type predict_forwarding(input req_item_type w);
      rsp_item_type r;
      logic         bcast;
      logic         arp;
      logic         hit;
      int           n;
      r = '0;
      r.route = ROUTE_NONE;
      case (w.opcode)
         OP_WIRED: begin
            bcast = (w.mac_addr == MAC_BROADCAST);
            arp = (w.ethertype == ETYPE_ARP);
            if (w.mac_addr == cfg_local_mac || (bcast && !arp))
               r.route = ROUTE_LOCAL;
            else if (link_connected && (w.mac_addr == learned_peer || (bcast && arp)))
               r.route = ROUTE_PEER;
         end
         OP_PEER_DATA: begin
            learned_peer = w.mac_addr;
         end
         OP_OPEN: begin
            // A count beyond the list depth only covers the whole list.
            n = (cfg_filter_count > ACL_DEPTH) ? ACL_DEPTH : int'(cfg_filter_count);
            hit = 1'b0;
            for (int i = 0; i < n; i++)
               if (acl[i] == w.mac_addr)
                  hit = 1'b1;
            if ((cfg_list_sense == LIST_SENSE_ALLOW) ? !hit : hit) begin
               r.disconnect = 1'b1;
            end else if (w.open_ok) begin
               active_chan = w.link_channel;
               learned_peer = w.mac_addr;
               link_connected = 1'b1;
            end
         end
         OP_CLOSE: begin
            link_connected = 1'b0;
            learned_peer = '0;
         end
         OP_WRITE: begin
            acl[w.entry_index] = w.mac_addr;
         end
         default: ;
      endcase
      r.link_up = link_connected;
      r.current_channel = active_chan;
      return r;
   endfunction

   function automatic req_item_type make_word(input opcode_type op, input mac_type mac,
                                              input etype_type etype, input logic ok,
                                              input chan_type chan, input entry_index_type idx);
      req_item_type w;
      w.opcode = op;
      w.mac_addr = mac;
      w.ethertype = etype;
      w.open_ok = ok;
      w.link_channel = chan;
      w.entry_index = idx;
      return w;
   endfunction

   // Random traffic leans on addresses the block knows, so that every route is reached.
   function automatic req_item_type random_word();
      req_item_type w;
      int unsigned  pick;
      int unsigned  sel;
      w = make_word(OP_WIRED, rand_mac(), 16'($urandom()), $urandom_range(0, 3) != 0,
                    16'($urandom()), 5'($urandom()));
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 99);
      if (pick < 50) begin
         if (sel < 20)
            w.mac_addr = cfg_local_mac;
         else if (sel < 40)
            w.mac_addr = learned_peer;
         else if (sel < 60)
            w.mac_addr = MAC_BROADCAST;
         else if (sel < 80)
            w.mac_addr = mac_pool[3'($urandom_range(0, 7))];
         sel = $urandom_range(0, 9);
         if (sel < 4)
            w.ethertype = ETYPE_ARP;
         else if (sel == 4)
            w.ethertype = '0;
         else if (sel == 5)
            w.ethertype = '1;
      end else if (pick < 62) begin
         w.opcode = OP_PEER_DATA;
         if (sel < 70)
            w.mac_addr = mac_pool[3'($urandom_range(0, 7))];
      end else if (pick < 74) begin
         w.opcode = OP_OPEN;
         if (sel < 40)
            w.mac_addr = mac_pool[3'($urandom_range(0, 7))];
         else if (sel < 70)
            w.mac_addr = acl[5'($urandom_range(0, ACL_DEPTH - 1))];
      end else if (pick < 82) begin
         w.opcode = OP_CLOSE;
      end else if (pick < 94) begin
         w.opcode = OP_WRITE;
         if (sel < 70)
            w.mac_addr = mac_pool[3'($urandom_range(0, 7))];
      end else begin
         sel = $urandom_range(0, 2);
         w.opcode = (sel == 0) ? OP_RSVD5 : (sel == 1) ? OP_RSVD6 : OP_RSVD7;
      end
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %0s", $realtime, what);
      mismatch_count++;
   endtask

   // Offers one word and returns at the edge where it is taken; valid stays high.
   task automatic send_word(input req_item_type w);
      int unsigned gap;
      gap = sender_gaps ? pick_idle_len() : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= w.opcode;
      req_bus.mac_addr <= w.mac_addr;
      req_bus.ethertype <= w.ethertype;
      req_bus.open_ok <= w.open_ok;
      req_bus.link_channel <= w.link_channel;
      req_bus.entry_index <= w.entry_index;
      do @(posedge clock); while (!req_bus.ready);
      expected_rsp_q.push_back(predict_forwarding(w));
      words_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input mac_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_LOCAL_MAC:    cfg_local_mac = data;
         CSR_LIST_SENSE:   cfg_list_sense = data[0];
         CSR_FILTER_COUNT: cfg_filter_count = data[FILTER_COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Registers change only once the block has returned every result.
   task automatic apply_config(input mac_type local_mac, input logic mode,
                               input filter_count_type count);
      drain_results();
      write_register(CSR_LOCAL_MAC, local_mac);
      write_register(CSR_LIST_SENSE, mac_type'(mode));
      write_register(CSR_FILTER_COUNT, mac_type'(count));
      csr_bus.valid <= 1'b0;
      settings_applied++;
   endtask

   // Every slot is written before any count can reach it.
   task automatic test_acl_load();
      for (int i = 0; i < 6; i++)
         mac_pool[i] = rand_mac();
      mac_pool[6] = '0;
      mac_pool[7] = MAC_BROADCAST;
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      for (int i = 0; i < ACL_DEPTH; i++)
         send_word(make_word(OP_WRITE,
                             (i == ACL_DEPTH - 1) ? MAC_BROADCAST :
                             (i % 2 == 0) ? mac_pool[(i / 2) % 8] : rand_mac(),
                             16'($urandom()), 1'($urandom()), 16'($urandom()),
                             entry_index_type'(i)));
   endtask

   task automatic test_directed_cases();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      // With local_mac still at reset, an all-zero destination belongs to the host.
      send_word(make_word(OP_WIRED, '0, 16'h1234, 1'b0, '0, '0));
      apply_config(mac_pool[2], LIST_SENSE_ALLOW, filter_count_type'(ACL_DEPTH));
      send_word(make_word(OP_WIRED, mac_pool[2], ETYPE_ARP, 1'b0, '0, '0));
      send_word(make_word(OP_WIRED, MAC_BROADCAST, '1, 1'b0, '0, '0));
      send_word(make_word(OP_WIRED, MAC_BROADCAST, ETYPE_ARP, 1'b0, '0, '0));
      send_word(make_word(OP_OPEN, rand_mac(), '0, 1'b1, 16'h00ff, '0));
      send_word(make_word(OP_OPEN, mac_pool[0], '0, 1'b0, 16'h1234, '0));
      send_word(make_word(OP_OPEN, mac_pool[0], '0, 1'b1, '1, '0));
      send_word(make_word(OP_WIRED, mac_pool[0], '0, 1'b0, '0, '0));
      send_word(make_word(OP_WIRED, MAC_BROADCAST, ETYPE_ARP, 1'b0, '0, '0));
      send_word(make_word(OP_WIRED, rand_mac(), 16'h0800, 1'b0, '0, '0));
      send_word(make_word(OP_PEER_DATA, mac_pool[1], '0, 1'b0, '0, '0));
      send_word(make_word(OP_WIRED, mac_pool[1], 16'h86dd, 1'b0, '0, '0));
      send_word(make_word(OP_CLOSE, '1, '1, 1'b1, '1, '1));
      // Learning still happens while the link is down, but nothing goes to the peer.
      send_word(make_word(OP_PEER_DATA, mac_pool[3], '0, 1'b0, '0, '0));
      send_word(make_word(OP_WIRED, mac_pool[3], '0, 1'b0, '0, '0));
      send_word(make_word(OP_RSVD5, '1, '1, 1'b1, '1, '1));
      send_word(make_word(OP_RSVD6, '1, '1, 1'b1, '1, '1));
      send_word(make_word(OP_RSVD7, '0, '0, 1'b0, '0, '0));
      send_word(make_word(OP_WRITE, MAC_BROADCAST, '0, 1'b0, '0, '1));
      apply_config(MAC_BROADCAST, LIST_SENSE_DENY, '1);
      send_word(make_word(OP_WIRED, MAC_BROADCAST, ETYPE_ARP, 1'b0, '0, '0));
      send_word(make_word(OP_OPEN, mac_pool[0], '0, 1'b1, 16'h5555, '0));
      send_word(make_word(OP_OPEN, rand_mac(), '0, 1'b1, '0, '0));
      send_word(make_word(OP_WIRED, MAC_BROADCAST, ETYPE_ARP, 1'b0, '0, '0));
   endtask

   task automatic test_random_configs();
      mac_type          local_mac;
      logic             mode;
      filter_count_type count;
      for (int k = 0; k < 7; k++) begin
         local_mac = rand_mac();
         case (k)
            0: begin mode = LIST_SENSE_ALLOW; count = 6'd32; local_mac = mac_pool[4]; end
            1: begin mode = LIST_SENSE_DENY;  count = 6'd0; end
            2: begin mode = LIST_SENSE_ALLOW; count = 6'd0;  local_mac = '0; end
            3: begin mode = LIST_SENSE_DENY;  count = '1;    local_mac = MAC_BROADCAST; end
            4: begin mode = LIST_SENSE_ALLOW; count = 6'd1; end
            5: begin mode = LIST_SENSE_DENY;  count = 6'd16; local_mac = mac_pool[5]; end
            default: begin mode = LIST_SENSE_ALLOW; count = 6'd40; end
         endcase
         apply_config(local_mac, mode, count);
         // Cycle through gap styles so that some phases run flat out.
         sender_gaps = (k % 4) < 2;
         receiver_stalls = (k % 4) == 0 || (k % 4) == 2;
         repeat (PHASE_WORDS) send_word(random_word());
      end
   endtask

   // The result side stops for a long stretch while words keep coming.
   task automatic test_output_backpressure();
      drain_results();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b1;
      rsp_hold_req = HOLD_CYCLES;
      repeat (60) send_word(random_word());
   endtask

   always @(posedge clock) begin : check_results
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.route = rsp_bus.route;
         got.disconnect = rsp_bus.disconnect;
         got.link_up = rsp_bus.link_up;
         got.current_channel = rsp_bus.current_channel;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result word arrived with no word outstanding");
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.route !== want.route)
               report_mismatch($sformatf("result %0d route %0d, expected %0d",
                                         results_checked, got.route, want.route));
            if (got.disconnect !== want.disconnect)
               report_mismatch($sformatf("result %0d disconnect %0b, expected %0b",
                                         results_checked, got.disconnect, want.disconnect));
            if (got.link_up !== want.link_up)
               report_mismatch($sformatf("result %0d link_up %0b, expected %0b",
                                         results_checked, got.link_up, want.link_up));
            if (got.current_channel !== want.current_channel)
               report_mismatch($sformatf("result %0d channel %h, expected %h", results_checked,
                                         got.current_channel, want.current_channel));
            results_checked++;
         end
      end
   end

   initial begin : result_receiver
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req != 0) begin
            stall_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (stall_left == 0 && receiver_stalls && $urandom_range(0, 3) == 0)
            stall_left = pick_idle_len();
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("l2_bridge_forward_filter verification failed");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= OP_WIRED;
      req_bus.mac_addr <= '0;
      req_bus.ethertype <= '0;
      req_bus.open_ok <= 1'b0;
      req_bus.link_channel <= '0;
      req_bus.entry_index <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_LOCAL_MAC;
      csr_bus.wdata <= '0;
      cfg_local_mac = '0;
      cfg_list_sense = LIST_SENSE_ALLOW;
      cfg_filter_count = '0;
      link_connected = 1'b0;
      learned_peer = '0;
      active_chan = '0;
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      rsp_hold_req = 0;
      mismatch_count = 0;
      words_sent = 0;
      results_checked = 0;
      settings_applied = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_acl_load();
      test_directed_cases();
      test_random_configs();
      test_output_backpressure();

      drain_results();
      repeat (8) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_rsp_q.size()));
      $display("Sent %0d words across %0d register settings and compared %0d results.",
               words_sent, settings_applied, results_checked);
      $display("Covered allow and deny lists, link open and close, learning and a %0d-cycle %s",
               HOLD_CYCLES, "result stall.");
      if (mismatch_count == 0)
         $display("l2_bridge_forward_filter verification clean");
      else
         $display("l2_bridge_forward_filter verification failed");
      $finish;
   end

endmodule

>>> l2_bridge_forward_filter.f
+incdir+hw/rtl
hw/rtl/l2bff_pkg.sv
hw/rtl/l2bff_if.sv
hw/rtl/l2bff_acl.sv
hw/rtl/l2bff_decide.sv
hw/rtl/l2_bridge_forward_filter.sv
dv/tb_l2_bridge_forward_filter.sv
